// File: rtl/cc_pkg.sv
// stream cipher package: widths, config layout, queue entry, back-end states
// and the quarter-round / state-setup helpers used by the back end
// no dependencies
package cc_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_WORDS  = 16;
    localparam int IDX_W      = 4;
    localparam int ROUNDS     = 20;
    localparam int ROUND_W    = 5;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_arr_t;

    // "expand 32-byte k"
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    // register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_W01,
        CFG_KEY_W23,
        CFG_KEY_W45,
        CFG_KEY_W67,
        CFG_NONCE_W01,
        CFG_NONCE_W2,
        CFG_INIT_CTR
    } cfg_idx_e;

    typedef struct packed {
        logic [63:0] key_w01;
        logic [63:0] key_w23;
        logic [63:0] key_w45;
        logic [63:0] key_w67;
        logic [63:0] nonce_w01;
        word_t       nonce_w2;
        word_t       initial_counter;
    } cfg_t;

    // one classified word on its way to the back end
    typedef struct packed {
        word_t            data;
        logic             new_block;
        word_t            counter;
        logic [IDX_W-1:0] idx;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_slot_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_EMIT
    } back_state_e;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_t;

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // full quarter round
    function automatic qr_t quarter(word_t a_in, word_t b_in, word_t c_in, word_t d_in);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        qr_t   r;
        a = a_in;
        b = b_in;
        c = c_in;
        d = d_in;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

    // starting state of a block
    function automatic state_arr_t init_state(cfg_t cfg, word_t ctr);
        state_arr_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = cfg.key_w01[31:0];
        s[5]  = cfg.key_w01[63:32];
        s[6]  = cfg.key_w23[31:0];
        s[7]  = cfg.key_w23[63:32];
        s[8]  = cfg.key_w45[31:0];
        s[9]  = cfg.key_w45[63:32];
        s[10] = cfg.key_w67[31:0];
        s[11] = cfg.key_w67[63:32];
        s[12] = ctr;
        s[13] = cfg.nonce_w01[31:0];
        s[14] = cfg.nonce_w01[63:32];
        s[15] = cfg.nonce_w2;
        return s;
    endfunction

    // one round: column round when diag is low, diagonal round when high
    function automatic state_arr_t one_round(state_arr_t x, logic diag);
        state_arr_t       y;
        qr_t              r;
        logic [1:0]       qv;
        logic [1:0]       bo;
        logic [1:0]       co;
        logic [1:0]       dof;
        logic [IDX_W-1:0] ai;
        logic [IDX_W-1:0] bi;
        logic [IDX_W-1:0] ci;
        logic [IDX_W-1:0] di;
        y   = x;
        bo  = diag ? 2'd1 : 2'd0;
        co  = diag ? 2'd2 : 2'd0;
        dof = diag ? 2'd3 : 2'd0;
        for (int q = 0; q < 4; q++) begin
            qv = 2'(q);
            ai = {2'd0, qv};
            bi = {2'd1, 2'(qv + bo)};
            ci = {2'd2, 2'(qv + co)};
            di = {2'd3, 2'(qv + dof)};
            r  = quarter(x[ai], x[bi], x[ci], x[di]);
            y[ai] = r.a;
            y[bi] = r.b;
            y[ci] = r.c;
            y[di] = r.d;
        end
        return y;
    endfunction

endpackage

// File: rtl/cc_if.sv
// valid/ready channel interfaces for the data words in and out
// depends on cc_pkg
interface cc_in_if;
    logic          valid;
    logic          ready;
    cc_pkg::word_t data_in;
    logic          restart;

    modport source (output valid, output data_in, output restart, input ready);
    modport sink   (input valid, input data_in, input restart, output ready);
endinterface

interface cc_out_if;
    logic          valid;
    logic          ready;
    cc_pkg::word_t data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/cc_front.sv
// front end: accepts input words, tracks word index and block counter and
// tags each word with whether a new keystream block must be built first
// depends on cc_pkg, cc_if
module cc_front (
    input  logic            clk,
    input  logic            rst_n,
    cc_in_if.sink           in_ch,
    input  cc_pkg::word_t   init_ctr,
    input  logic            q_full,
    output cc_pkg::q_slot_t push
);
    import cc_pkg::*;

    logic [IDX_W-1:0] widx_reg;
    logic [IDX_W-1:0] widx_next;
    word_t            ctr_reg;
    word_t            ctr_next;
    logic             need_reg;
    logic             need_next;

    logic             acc;
    logic             nb;
    word_t            cnt;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx_inc;

    assign in_ch.ready = !q_full;
    assign acc         = in_ch.valid && in_ch.ready;

    // classify the word
    assign nb      = in_ch.restart || need_reg;
    assign cnt     = in_ch.restart ? init_ctr : ctr_reg;
    assign idx     = nb ? '0 : widx_reg;
    assign idx_inc = idx + 1'b1;

    always_comb
    begin
        push.valid           = acc;
        push.entry.data      = in_ch.data_in;
        push.entry.new_block = nb;
        push.entry.counter   = cnt;
        push.entry.idx       = idx;
    end

    // counter and index bookkeeping
    always_comb
    begin
        widx_next = widx_reg;
        ctr_next  = ctr_reg;
        need_next = need_reg;
        if (acc)
        begin
            widx_next = idx_inc;
            need_next = (idx_inc == '0);
            if (nb)
            begin
                ctr_next = cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg <= '0;
            ctr_reg  <= '0;
            need_reg <= 1'b1;
        end
        else
        begin
            widx_reg <= widx_next;
            ctr_reg  <= ctr_next;
            need_reg <= need_next;
        end
    end

endmodule

// File: rtl/cc_queue.sv
// short register queue between front end and back end
// depends on cc_pkg
module cc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  cc_pkg::q_slot_t push,
    input  logic            pop,
    output logic            full,
    output cc_pkg::q_slot_t head
);
    import cc_pkg::*;

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        unique case ({push.valid, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// File: rtl/cc_back.sv
// back end: iterative round core, keystream block store and output register
// depends on cc_pkg, cc_if
module cc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cc_pkg::cfg_t    cfg,
    input  cc_pkg::q_slot_t head,
    output logic            pop,
    cc_out_if.source        out_ch
);
    import cc_pkg::*;

    back_state_e          state_reg;
    back_state_e          state_next;
    logic [ROUND_W-1:0]   step_reg;
    logic [ROUND_W-1:0]   step_next;
    state_arr_t           work_reg;
    state_arr_t           work_next;
    state_arr_t           ks_reg;
    state_arr_t           ks_next;
    word_t                ctr_reg;
    word_t                ctr_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    word_t                out_data_reg;
    word_t                out_data_next;

    logic                 slot_free;
    state_arr_t           init_w;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign init_w    = init_state(cfg, ctr_reg);

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = out_data_reg;

    // sequencer: build a new block first when tagged, then xor and emit
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        work_next      = work_reg;
        ks_next        = ks_reg;
        ctr_next       = ctr_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.entry.new_block)
                    begin
                        ctr_next   = head.entry.counter;
                        work_next  = init_state(cfg, head.entry.counter);
                        step_next  = '0;
                        state_next = BK_ROUND;
                    end
                    else if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = head.entry.data ^ ks_reg[head.entry.idx];
                        pop            = 1'b1;
                    end
                end
            end
            BK_ROUND:
            begin
                work_next = one_round(work_reg, step_reg[0]);
                step_next = step_reg + 1'b1;
                if (step_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = BK_ADD;
                end
            end
            BK_ADD:
            begin
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    ks_next[k] = work_reg[k] + init_w[k];
                end
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = head.entry.data ^ ks_reg[head.entry.idx];
                    pop            = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        ks_reg       <= ks_next;
        ctr_reg      <= ctr_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/chacha20_stream_cipher_top.sv
// Stream cipher top level: XORs each 32-bit word with ChaCha20 keystream. A word
// that needs no new keystream block is held in the queue, then in the output
// register; such words flow at one per cycle while the output is ready and no
// block is being built. The first word of each 16-word block waits for the round
// core, which does one full round per cycle: it loads the state, runs the 20
// rounds, adds the starting state and emits the word. A four-entry queue lets
// input keep flowing while a block is being built, and an output register lets
// the block work on while a result waits. Key, nonce and initial counter are to
// be written through the config port only while the block is idle; the block does
// not enforce it. Key and nonce apply at the next block, the initial counter at
// the next restart; with none, the first block after reset uses counter 0.
// depends on cc_pkg, cc_if, cc_front, cc_queue, cc_back
module chacha20_stream_cipher_top (
    input  logic                             clk,
    input  logic                             rst_n,
    cc_in_if.sink                            in_ch,
    cc_out_if.source                         out_ch,
    input  logic                             cfg_we,
    input  logic [cc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cc_pkg::*;

    cfg_t    cfg_reg;
    q_slot_t push;
    q_slot_t head;
    logic    q_full;
    logic    pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_KEY_W01:   cfg_reg.key_w01         <= cfg_wdata;
                CFG_KEY_W23:   cfg_reg.key_w23         <= cfg_wdata;
                CFG_KEY_W45:   cfg_reg.key_w45         <= cfg_wdata;
                CFG_KEY_W67:   cfg_reg.key_w67         <= cfg_wdata;
                CFG_NONCE_W01: cfg_reg.nonce_w01       <= cfg_wdata;
                CFG_NONCE_W2:  cfg_reg.nonce_w2        <= cfg_wdata[WORD_W-1:0];
                CFG_INIT_CTR:  cfg_reg.initial_counter <= cfg_wdata[WORD_W-1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    cc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .init_ctr (cfg_reg.initial_counter),
        .q_full   (q_full),
        .push     (push)
    );

    cc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    cc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // queue is never written when full
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_full)
        else $error("queue written while full");

    // back end only takes an entry that is there
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");

    // a restart transaction always starts a fresh block at word zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.restart)
        |-> (push.valid && push.entry.new_block && push.entry.idx == '0))
        else $error("restart not tagged as new block");

    // a result shows up only after an entry left the queue
    assert property (@(posedge clk) disable iff (!rst_n) $rose(out_ch.valid) |-> $past(pop))
        else $error("output valid without a pop");

endmodule
